// ===== hw/rtl/seg_hit_pkg.sv =====
// Package with the widths, reset value and nearest-part codes of the segment hit test.
package seg_hit_pkg;

   localparam int COORD_W = 18;
   localparam int TOL_W   = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SQ_W    = PROD_W - 1;
   localparam int LEN_W   = PROD_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int HALF_W  = LEN_W / 2;
   localparam int TSQ_W   = 2 * TOL_W;
   localparam int WIDE_W  = 2 * LEN_W;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

   typedef logic [1:0] part_type;

   localparam part_type PART_FIRST    = 2'd0;
   localparam part_type PART_INTERIOR = 2'd1;
   localparam part_type PART_SECOND   = 2'd2;

endpackage

// ===== hw/rtl/segment_hit_test.sv =====
// Pipelined test of whether a point lies within a set distance of a line segment.
//
// A request carries a query point and the two endpoints of a segment, all
// signed fixed point with four fraction bits. It is accepted at a clock edge
// where start is high and busy is low. Busy is always low, so a new request
// may be accepted at every clock edge and the throughput is one request per
// cycle.
// Each request gives exactly one result. The result stands on rsp_hit and
// rsp_nearest_part for one cycle while rsp_valid is high. The pipeline has
// six register stages: differences, products, sums, classification with
// partial products, wide sums, and the output register.
// The receiver cannot stall, so results leave in request order without gaps.
// The user writes the tolerance through csr_write_en and csr_write_data only while
// no request is in flight; the block does not enforce this. Its square is registered.
// A synchronous reset empties the pipeline and sets the tolerance to 1.0.
module segment_hit_test (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic signed [seg_hit_pkg::COORD_W-1:0]        req_point_x,
   input  logic signed [seg_hit_pkg::COORD_W-1:0]        req_point_y,
   input  logic signed [seg_hit_pkg::COORD_W-1:0]        req_start_x,
   input  logic signed [seg_hit_pkg::COORD_W-1:0]        req_start_y,
   input  logic signed [seg_hit_pkg::COORD_W-1:0]        req_end_x,
   input  logic signed [seg_hit_pkg::COORD_W-1:0]        req_end_y,
   input  logic                                         csr_write_en,
   input  logic        [seg_hit_pkg::TOL_W-1:0]          csr_write_data,
   output logic                                         rsp_valid,
   output logic                                         rsp_hit,
   output seg_hit_pkg::part_type                        rsp_nearest_part
);

   localparam int DW = seg_hit_pkg::DIFF_W;
   localparam int PW = seg_hit_pkg::PROD_W;
   localparam int SW = seg_hit_pkg::SQ_W;
   localparam int LW = seg_hit_pkg::LEN_W;
   localparam int OW = seg_hit_pkg::DOT_W;
   localparam int HW = seg_hit_pkg::HALF_W;
   localparam int TW = seg_hit_pkg::TSQ_W;
   localparam int WW = seg_hit_pkg::WIDE_W;
   localparam int XW = TW + HW;

   // Tolerance squared.
   logic [TW-1:0] tol_sq_ff;
   logic [TW-1:0] tol_sq_in;

   // Stage 1: differences.
   logic                 vld1_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, vx_ff, vy_ff, wx_ff, wy_ff;
   logic signed [DW-1:0] dx_in, dy_in, vx_in, vy_in, wx_in, wy_in;

   // Stage 2: products.
   logic                 vld2_ff;
   logic signed [PW-1:0] pdd_x_ff, pdd_y_ff, pvd_x_ff, pvd_y_ff;
   logic signed [PW-1:0] pvv_x_ff, pvv_y_ff, pww_x_ff, pww_y_ff;
   logic signed [PW-1:0] pcr_a_ff, pcr_b_ff;

   // Stage 3: sums.
   logic                 vld3_ff;
   logic [LW-1:0]        len_ff, v2_ff, w2_ff, cmag_ff;
   logic [LW-1:0]        len_in, v2_in, w2_in, cmag_in;
   logic signed [OW-1:0] dot_ff, dot_in, cross_in;

   // Stage 4: classification and partial products.
   logic                 vld4_ff;
   seg_hit_pkg::part_type part4_ff, part4_in;
   logic                 vhit4_ff, whit4_ff;
   logic [LW-1:0]        chh_ff, chl_ff, cll_ff;
   logic [XW-1:0]        thi_ff, tlo_ff;

   // Stage 5: wide sums.
   logic                 vld5_ff;
   seg_hit_pkg::part_type part5_ff;
   logic                 vhit5_ff, whit5_ff;
   logic [WW-1:0]        lhs_ff, rhs_ff, lhs_in, rhs_in;

   // Stage 6: output.
   logic                 hit_in;

   assign busy = 1'b0;

   assign tol_sq_in = {{(TW - seg_hit_pkg::TOL_W){1'b0}}, csr_write_data}
                    * {{(TW - seg_hit_pkg::TOL_W){1'b0}}, csr_write_data};

   assign dx_in = {req_end_x[seg_hit_pkg::COORD_W-1], req_end_x}
                - {req_start_x[seg_hit_pkg::COORD_W-1], req_start_x};
   assign dy_in = {req_end_y[seg_hit_pkg::COORD_W-1], req_end_y}
                - {req_start_y[seg_hit_pkg::COORD_W-1], req_start_y};
   assign vx_in = {req_point_x[seg_hit_pkg::COORD_W-1], req_point_x}
                - {req_start_x[seg_hit_pkg::COORD_W-1], req_start_x};
   assign vy_in = {req_point_y[seg_hit_pkg::COORD_W-1], req_point_y}
                - {req_start_y[seg_hit_pkg::COORD_W-1], req_start_y};
   assign wx_in = {req_point_x[seg_hit_pkg::COORD_W-1], req_point_x}
                - {req_end_x[seg_hit_pkg::COORD_W-1], req_end_x};
   assign wy_in = {req_point_y[seg_hit_pkg::COORD_W-1], req_point_y}
                - {req_end_y[seg_hit_pkg::COORD_W-1], req_end_y};

   always_comb begin
      len_in   = {1'b0, pdd_x_ff[SW-1:0]} + {1'b0, pdd_y_ff[SW-1:0]};
      v2_in    = {1'b0, pvv_x_ff[SW-1:0]} + {1'b0, pvv_y_ff[SW-1:0]};
      w2_in    = {1'b0, pww_x_ff[SW-1:0]} + {1'b0, pww_y_ff[SW-1:0]};
      dot_in   = {pvd_x_ff[PW-1], pvd_x_ff} + {pvd_y_ff[PW-1], pvd_y_ff};
      cross_in = {pcr_a_ff[PW-1], pcr_a_ff} - {pcr_b_ff[PW-1], pcr_b_ff};
      if (cross_in[OW-1]) begin
         cmag_in = LW'(-cross_in);
      end else begin
         cmag_in = cross_in[LW-1:0];
      end
   end

   always_comb begin
      if (len_ff == '0 || dot_ff[OW-1] || dot_ff == '0) begin
         part4_in = seg_hit_pkg::PART_FIRST;
      end else if (dot_ff[LW-1:0] >= len_ff) begin
         part4_in = seg_hit_pkg::PART_SECOND;
      end else begin
         part4_in = seg_hit_pkg::PART_INTERIOR;
      end
   end

   assign lhs_in = {chh_ff, {(2 * HW){1'b0}}}
                 + {{(HW - 1){1'b0}}, chl_ff, {(HW + 1){1'b0}}}
                 + {{LW{1'b0}}, cll_ff};
   assign rhs_in = {{(WW - XW - HW){1'b0}}, thi_ff, {HW{1'b0}}}
                 + {{(WW - XW){1'b0}}, tlo_ff};

   always_comb begin
      case (part5_ff)
         seg_hit_pkg::PART_INTERIOR: hit_in = (lhs_ff <= rhs_ff);
         seg_hit_pkg::PART_SECOND:   hit_in = whit5_ff;
         default:                    hit_in = vhit5_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_sq_ff <= TW'(seg_hit_pkg::TOL_RESET) * TW'(seg_hit_pkg::TOL_RESET);
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         vld3_ff   <= 1'b0;
         vld4_ff   <= 1'b0;
         vld5_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write_en) begin
            tol_sq_ff <= tol_sq_in;
         end
         vld1_ff   <= start && !busy;
         vld2_ff   <= vld1_ff;
         vld3_ff   <= vld2_ff;
         vld4_ff   <= vld3_ff;
         vld5_ff   <= vld4_ff;
         rsp_valid <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      wx_ff <= wx_in;
      wy_ff <= wy_in;

      pdd_x_ff <= dx_ff * dx_ff;
      pdd_y_ff <= dy_ff * dy_ff;
      pvd_x_ff <= vx_ff * dx_ff;
      pvd_y_ff <= vy_ff * dy_ff;
      pvv_x_ff <= vx_ff * vx_ff;
      pvv_y_ff <= vy_ff * vy_ff;
      pww_x_ff <= wx_ff * wx_ff;
      pww_y_ff <= wy_ff * wy_ff;
      pcr_a_ff <= vx_ff * dy_ff;
      pcr_b_ff <= vy_ff * dx_ff;

      len_ff  <= len_in;
      v2_ff   <= v2_in;
      w2_ff   <= w2_in;
      dot_ff  <= dot_in;
      cmag_ff <= cmag_in;

      part4_ff <= part4_in;
      vhit4_ff <= (v2_ff <= {{(LW - TW){1'b0}}, tol_sq_ff});
      whit4_ff <= (w2_ff <= {{(LW - TW){1'b0}}, tol_sq_ff});
      chh_ff   <= {{HW{1'b0}}, cmag_ff[LW-1:HW]} * {{HW{1'b0}}, cmag_ff[LW-1:HW]};
      chl_ff   <= {{HW{1'b0}}, cmag_ff[LW-1:HW]} * {{HW{1'b0}}, cmag_ff[HW-1:0]};
      cll_ff   <= {{HW{1'b0}}, cmag_ff[HW-1:0]} * {{HW{1'b0}}, cmag_ff[HW-1:0]};
      thi_ff   <= {{HW{1'b0}}, tol_sq_ff} * {{TW{1'b0}}, len_ff[LW-1:HW]};
      tlo_ff   <= {{HW{1'b0}}, tol_sq_ff} * {{TW{1'b0}}, len_ff[HW-1:0]};

      part5_ff <= part4_ff;
      vhit5_ff <= vhit4_ff;
      whit5_ff <= whit4_ff;
      lhs_ff   <= lhs_in;
      rhs_ff   <= rhs_in;

      rsp_hit          <= hit_in;
      rsp_nearest_part <= part5_ff;
   end

endmodule
